>>> hdl/rscm_pkg.sv
// ----------------------------------------------------------------------------
// rscm_pkg: shared types and constants of the rotate source coordinate mapper
// register indexes, fixed field widths and width helpers for the datapath
// ----------------------------------------------------------------------------
package rscm_pkg;

  // fixed field widths
  localparam int unsigned DEST_W       = 13;
  localparam int unsigned SIDE_W       = 13;
  localparam int unsigned COORD_W      = 12;
  localparam int unsigned INDEX_W      = 24;
  localparam int unsigned COEF_W       = 18;
  localparam int unsigned SRC_CENTRE_W = 29;
  localparam int unsigned DST_CENTRE_W = 30;
  localparam int unsigned CFG_DATA_W   = 30;
  localparam int unsigned CFG_IDX_W    = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COSINE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SINE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_CX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_CY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_CX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DST_CY    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_W     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H     = 3'd7;

  // geometry settings seen by the datapath, sides already clamped
  typedef struct packed {
    logic [SRC_CENTRE_W-1:0] src_cx;
    logic [SRC_CENTRE_W-1:0] src_cy;
    logic [DST_CENTRE_W-1:0] dst_cx;
    logic [DST_CENTRE_W-1:0] dst_cy;
    logic [SIDE_W-1:0]       src_w;
    logic [SIDE_W-1:0]       src_h;
  } cfg_t;

  // width of the centred destination offset
  function automatic int unsigned rx_width(int unsigned fb);
    return ((DEST_W + fb > DST_CENTRE_W) ? DEST_W + fb : DST_CENTRE_W) + 1;
  endfunction

  // coefficient width, wide enough to hold one at reset
  function automatic int unsigned cos_width(int unsigned fb);
    return (fb + 2 > COEF_W) ? fb + 2 : COEF_W;
  endfunction

  // width of the rotated fixed point sum
  function automatic int unsigned sum_width(int unsigned fb);
    return rx_width(fb) + cos_width(fb) - fb + 2;
  endfunction

  // width of the rounded signed pixel coordinate
  function automatic int unsigned px_width(int unsigned fb);
    return (sum_width(fb) + 1 - fb > SIDE_W + 1) ? sum_width(fb) + 1 - fb : SIDE_W + 1;
  endfunction

endpackage

>>> hdl/rscm_cfg_regs.sv
// ----------------------------------------------------------------------------
// rscm_cfg_regs: configuration registers
// write-only register file for rotation coefficients, centres and source size
// ----------------------------------------------------------------------------
module rscm_cfg_regs import rscm_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned MAX_SIDE      = 4096,
  parameter int unsigned COS_W         = 18
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic signed [COS_W-1:0] cos_o,
  output logic signed [COS_W-1:0] sin_o,
  output cfg_t                    cfg_o
);

  logic signed [COS_W-1:0]  cos_q, sin_q;
  logic [SRC_CENTRE_W-1:0]  src_cx_q, src_cy_q;
  logic [DST_CENTRE_W-1:0]  dst_cx_q, dst_cy_q;
  logic [SIDE_W-1:0]        src_w_q, src_h_q;

  // register writes, coefficients sign-extended from their field
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q    <= COS_W'(1) << FRACTION_BITS;
      sin_q    <= '0;
      src_cx_q <= '0;
      src_cy_q <= '0;
      dst_cx_q <= '0;
      dst_cy_q <= '0;
      src_w_q  <= '0;
      src_h_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_COSINE: cos_q    <= COS_W'($signed(cfg_wdata_i[COEF_W-1:0]));
        REG_SINE:   sin_q    <= COS_W'($signed(cfg_wdata_i[COEF_W-1:0]));
        REG_SRC_CX: src_cx_q <= cfg_wdata_i[SRC_CENTRE_W-1:0];
        REG_SRC_CY: src_cy_q <= cfg_wdata_i[SRC_CENTRE_W-1:0];
        REG_DST_CX: dst_cx_q <= cfg_wdata_i[DST_CENTRE_W-1:0];
        REG_DST_CY: dst_cy_q <= cfg_wdata_i[DST_CENTRE_W-1:0];
        REG_SRC_W:  src_w_q  <= cfg_wdata_i[SIDE_W-1:0];
        REG_SRC_H:  src_h_q  <= cfg_wdata_i[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // oversized sides are limited to the largest supported side
  assign cos_o        = cos_q;
  assign sin_o        = sin_q;
  assign cfg_o.src_cx = src_cx_q;
  assign cfg_o.src_cy = src_cy_q;
  assign cfg_o.dst_cx = dst_cx_q;
  assign cfg_o.dst_cy = dst_cy_q;
  assign cfg_o.src_w  = ({19'd0, src_w_q} > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : src_w_q;
  assign cfg_o.src_h  = ({19'd0, src_h_q} > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : src_h_q;

endmodule

>>> hdl/rscm_rotate.sv
// ----------------------------------------------------------------------------
// rscm_rotate: inverse rotation pipeline
// input register, centring, four products, floor shift, sum and rounding
// ----------------------------------------------------------------------------
module rscm_rotate import rscm_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned COS_W         = 18,
  parameter int unsigned PX_W          = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [DEST_W-1:0]       dest_x_i,
  input  logic [DEST_W-1:0]       dest_y_i,
  input  logic signed [COS_W-1:0] cos_i,
  input  logic signed [COS_W-1:0] sin_i,
  input  cfg_t                    cfg_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [PX_W-1:0]  px_o,
  output logic signed [PX_W-1:0]  py_o
);

  localparam int unsigned FB     = FRACTION_BITS;
  localparam int unsigned RX_W   = rx_width(FB);
  localparam int unsigned PROD_W = RX_W + COS_W;
  localparam int unsigned SH_W   = PROD_W - FB;
  localparam int unsigned SUM_W  = sum_width(FB);
  localparam logic [SUM_W:0] HALF = (SUM_W + 1)'(1) << (FB - 1);

  // stage valids and load enables, a stage loads when empty or draining
  logic a_v_q, b_v_q, c_v_q, d_v_q;
  logic a_ld, b_ld, c_ld, d_ld;

  assign d_ld = !d_v_q || ready_i;
  assign c_ld = !c_v_q || d_ld;
  assign b_ld = !b_v_q || c_ld;
  assign a_ld = !a_v_q || b_ld;

  assign in_stall_o = !a_ld;
  assign valid_o    = d_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      if (a_ld) a_v_q <= in_valid_i;
      if (b_ld) b_v_q <= a_v_q;
      if (c_ld) c_v_q <= b_v_q;
      if (d_ld) d_v_q <= c_v_q;
    end
  end

  // input register
  logic [DEST_W-1:0] a_dx_q, a_dy_q;

  always_ff @(posedge clk_i) begin
    if (a_ld && in_valid_i) begin
      a_dx_q <= dest_x_i;
      a_dy_q <= dest_y_i;
    end
  end

  // centre the destination coordinate
  logic signed [RX_W-1:0] b_rx_d, b_ry_d, b_rx_q, b_ry_q;

  assign b_rx_d = $signed(RX_W'({a_dx_q, {FB{1'b0}}})) - $signed(RX_W'(cfg_i.dst_cx));
  assign b_ry_d = $signed(RX_W'({a_dy_q, {FB{1'b0}}})) - $signed(RX_W'(cfg_i.dst_cy));

  always_ff @(posedge clk_i) begin
    if (b_ld && a_v_q) begin
      b_rx_q <= b_rx_d;
      b_ry_q <= b_ry_d;
    end
  end

  // rotation products
  logic signed [PROD_W-1:0] c_xc_q, c_xs_q, c_yc_q, c_ys_q;

  always_ff @(posedge clk_i) begin
    if (c_ld && b_v_q) begin
      c_xc_q <= PROD_W'(b_rx_q) * PROD_W'(cos_i);
      c_xs_q <= PROD_W'(b_rx_q) * PROD_W'(sin_i);
      c_yc_q <= PROD_W'(b_ry_q) * PROD_W'(cos_i);
      c_ys_q <= PROD_W'(b_ry_q) * PROD_W'(sin_i);
    end
  end

  // floor shift each product, add source centre, round to nearest pixel
  logic signed [SUM_W-1:0] sx, sy;
  logic signed [SUM_W:0]   rsx, rsy;
  logic signed [PX_W-1:0]  d_px_q, d_py_q;

  assign sx = SUM_W'(SH_W'(c_xc_q >>> FB)) - SUM_W'(SH_W'(c_ys_q >>> FB))
            + SUM_W'($signed({1'b0, cfg_i.src_cx}));
  assign sy = SUM_W'(SH_W'(c_xs_q >>> FB)) + SUM_W'(SH_W'(c_yc_q >>> FB))
            + SUM_W'($signed({1'b0, cfg_i.src_cy}));
  assign rsx = (SUM_W + 1)'(sx) + $signed(HALF);
  assign rsy = (SUM_W + 1)'(sy) + $signed(HALF);

  always_ff @(posedge clk_i) begin
    if (d_ld && c_v_q) begin
      d_px_q <= PX_W'(rsx >>> FB);
      d_py_q <= PX_W'(rsy >>> FB);
    end
  end

  assign px_o = d_px_q;
  assign py_o = d_py_q;

  // a stalled last stage keeps its beat
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_v_q && !ready_i |=> d_v_q && $stable(d_px_q) && $stable(d_py_q))
    else $error("rotate stage lost a stalled beat");

endmodule

>>> hdl/rscm_bounds.sv
// ----------------------------------------------------------------------------
// rscm_bounds: bounds check and output register
// tests the rounded point against the source and forms the linear index
// ----------------------------------------------------------------------------
module rscm_bounds import rscm_pkg::*; #(
  parameter int unsigned PX_W = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic signed [PX_W-1:0] px_i,
  input  logic signed [PX_W-1:0] py_i,
  input  cfg_t                   cfg_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   inside_res_o,
  output logic [COORD_W-1:0]     source_x_o,
  output logic [COORD_W-1:0]     source_y_o,
  output logic [INDEX_W-1:0]     source_index_o
);

  localparam int unsigned IDX_FULL_W = 2 * SIDE_W + 1;

  logic                  ld;
  logic                  in_src;
  logic [SIDE_W-1:0]     ux, uy;
  logic [IDX_FULL_W-1:0] idx;

  logic                  out_valid_q;
  logic                  inside_q;
  logic [COORD_W-1:0]    source_x_q, source_y_q;
  logic [INDEX_W-1:0]    source_index_q;

  assign ld      = !out_valid_q || !out_stall_i;
  assign ready_o = ld;

  // inside test and row-major index
  assign in_src = !px_i[PX_W-1] && !py_i[PX_W-1]
               && (px_i < $signed(PX_W'(cfg_i.src_w)))
               && (py_i < $signed(PX_W'(cfg_i.src_h)));
  assign ux  = px_i[SIDE_W-1:0];
  assign uy  = py_i[SIDE_W-1:0];
  assign idx = IDX_FULL_W'(uy) * IDX_FULL_W'(cfg_i.src_w) + IDX_FULL_W'(ux);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld) begin
      out_valid_q <= valid_i;
    end
  end

  // result register, background pixels read as zero
  always_ff @(posedge clk_i) begin
    if (ld && valid_i) begin
      inside_q       <= in_src;
      source_x_q     <= in_src ? ux[COORD_W-1:0] : '0;
      source_y_q     <= in_src ? uy[COORD_W-1:0] : '0;
      source_index_q <= in_src ? idx[INDEX_W-1:0] : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign inside_res_o   = inside_q;
  assign source_x_o     = source_x_q;
  assign source_y_o     = source_y_q;
  assign source_index_o = source_index_q;

  // background beats carry no coordinates
  a_background_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !inside_res_o |->
      source_x_o == '0 && source_y_o == '0 && source_index_o == '0)
    else $error("background beat with non-zero coordinates");

  // an inside beat lies within the source
  a_inside_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && inside_res_o |->
      (SIDE_W'(source_x_o) < cfg_i.src_w) && (SIDE_W'(source_y_o) < cfg_i.src_h))
    else $error("inside beat outside the source");

endmodule

>>> hdl/rotate_source_coordinate_mapper_unit.sv
// ----------------------------------------------------------------------------
// rotate_source_coordinate_mapper_unit: nearest-neighbour rotation mapper
// maps each destination pixel back into the source image
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   dest_x_i, dest_y_i
// out      output     out_valid_o / out_stall_i inside_res_o, source_x_o,
//                                               source_y_o, source_index_o
// cfg      input      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// one beat per cycle sustained while out_stall_i is low; a taken beat passes
// through input register, centring, products, rounding, bounds/index
// every stage loads when empty or draining, so bubbles are absorbed
// rst_ni clears the stage valids and loads the register reset values
// an output stall holds the result and backs up stage by stage
// ----------------------------------------------------------------------------
module rotate_source_coordinate_mapper_unit import rscm_pkg::*; #(
  parameter int unsigned MAX_SIDE      = 4096,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DEST_W-1:0]     dest_x_i,
  input  logic [DEST_W-1:0]     dest_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  inside_res_o,
  output logic [COORD_W-1:0]    source_x_o,
  output logic [COORD_W-1:0]    source_y_o,
  output logic [INDEX_W-1:0]    source_index_o
);

  localparam int unsigned COS_W = cos_width(FRACTION_BITS);
  localparam int unsigned PX_W  = px_width(FRACTION_BITS);

  logic signed [COS_W-1:0] cos_w, sin_w;
  cfg_t                    cfg;
  logic                    rot_valid, rot_ready;
  logic signed [PX_W-1:0]  px, py;

  // configuration registers
  rscm_cfg_regs #(
    .FRACTION_BITS (FRACTION_BITS),
    .MAX_SIDE      (MAX_SIDE),
    .COS_W         (COS_W)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cos_o       (cos_w),
    .sin_o       (sin_w),
    .cfg_o       (cfg)
  );

  // rotation pipeline
  rscm_rotate #(
    .FRACTION_BITS (FRACTION_BITS),
    .COS_W         (COS_W),
    .PX_W          (PX_W)
  ) u_rotate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .dest_x_i   (dest_x_i),
    .dest_y_i   (dest_y_i),
    .cos_i      (cos_w),
    .sin_i      (sin_w),
    .cfg_i      (cfg),
    .valid_o    (rot_valid),
    .ready_i    (rot_ready),
    .px_o       (px),
    .py_o       (py)
  );

  // bounds check and result register
  rscm_bounds #(
    .PX_W (PX_W)
  ) u_bounds (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (rot_valid),
    .ready_o        (rot_ready),
    .px_i           (px),
    .py_i           (py),
    .cfg_i          (cfg),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .inside_res_o   (inside_res_o),
    .source_x_o     (source_x_o),
    .source_y_o     (source_y_o),
    .source_index_o (source_index_o)
  );

  // with the output empty every stage can move, so input is never held
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output register empty");

endmodule
